FILE: rtl/pitch_event_note_segmenter_top_macros.svh
// Assertion macros shared by the pitch event note segmenter RTL.
`ifndef PITCH_EVENT_NOTE_SEGMENTER_TOP_MACROS_SVH
`define PITCH_EVENT_NOTE_SEGMENTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SEG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segmenter check failed");
`define SEG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segmenter check failed");
`else
`define SEG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SEG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/pens_pkg.sv
// Types and constants of the pitch event note segmenter.
package pens_pkg;

    localparam int PITCH_W = 15;
    localparam int FIELD_W = 16;
    localparam int NOTE_W  = 7;
    localparam int CFG_W   = 16;

    localparam logic CFG_PITCH_TOL = 1'b0;
    localparam logic CFG_MAX_CAND  = 1'b1;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [PITCH_W-1:0] TOL_RESET  = 15'd128;
    localparam logic [FIELD_W-1:0] MAXD_RESET = 16'd50;
    localparam logic [NOTE_W-1:0]  NOTE_MAX   = 7'd127;

    typedef struct packed {
        logic               op;
        logic [PITCH_W-1:0] pitch;
        logic [FIELD_W-1:0] event_duration;
        logic [FIELD_W-1:0] event_pause;
    } evt_t;

    typedef struct packed {
        logic [NOTE_W-1:0]  note_number;
        logic [PITCH_W-1:0] mean_pitch;
        logic [FIELD_W-1:0] note_duration;
        logic [FIELD_W-1:0] note_pause;
    } note_t;

endpackage

FILE: rtl/pitch_event_note_segmenter_top.sv
// Top level of the pitch event note segmenter.
//
// Pitch events and flush requests arrive on the evt channel; finished notes
// leave on the note channel. A transaction completes at a rising edge where
// valid is high and stall is low on that channel.
// The block works on one transaction at a time and stalls the evt channel
// until it is done. A flush, a pause, a new candidate or a closing pitch is
// decided in the DECIDE state that follows acceptance, which is also where
// its note is loaded into the output register. A merge keeps the block busy
// after acceptance for the decision, two passes through the shared
// multiplier, one add, a restoring divider that yields one bit of the mean
// pitch per cycle, and the final update.
// A merge with zero total duration skips the divider.
// A waiting note does not block the next event, but the block holds in its
// emitting step while the output register is still occupied.
// Reset sets pitch_tolerance to 128, max_candidate_duration to 50 and
// clears both notes. The configuration port writes one register per cycle
// and is to be used only while the block is idle.
module pitch_event_note_segmenter_top #(
    parameter int DURATION_BITS   = 16,
    parameter int PITCH_FRAC_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       evt_valid,
    output logic                       evt_stall,
    input  pens_pkg::evt_t             evt,
    output logic                       note_valid,
    input  logic                       note_stall,
    output pens_pkg::note_t            note,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [pens_pkg::CFG_W-1:0] cfg_data
);

`include "pitch_event_note_segmenter_top_macros.svh"

    localparam int DB  = DURATION_BITS;
    localparam int PW  = pens_pkg::PITCH_W;
    localparam int FW  = pens_pkg::FIELD_W;
    localparam int MW  = PW + DB;
    localparam int NW  = DB + 16;
    localparam int CW  = (DB > FW) ? DB : FW;
    localparam int XW  = 17;
    localparam logic [XW-1:0] FRAC_MASK = (XW'(1) << PITCH_FRAC_BITS) - XW'(1);
    localparam logic [XW-1:0] FRAC_HALF = XW'(1) << (PITCH_FRAC_BITS - 1);
    localparam logic [3:0]    DIV_LAST  = 4'(PW - 1);

    typedef enum logic [2:0] {
        IDLE,
        DECIDE,
        MUL_P,
        MUL_E,
        ACCUM,
        DIVIDE,
        FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [PW-1:0]       tol_reg, tol_next;
    logic [FW-1:0]       maxd_reg, maxd_next;
    logic                active_reg, active_next;
    logic [PW-1:0]       cur_pitch_reg, cur_pitch_next;
    logic [DB-1:0]       cur_dur_reg, cur_dur_next;
    logic [PW-1:0]       cand_pitch_reg, cand_pitch_next;
    logic [DB-1:0]       cand_dur_reg, cand_dur_next;
    logic                op_reg, op_next;
    logic [PW-1:0]       e_reg, e_next;
    logic [DB-1:0]       n_reg, n_next;
    logic [FW-1:0]       pause_reg, pause_next;
    logic                tgt_cand_reg, tgt_cand_next;
    logic [MW-1:0]       prod_reg, prod_next;
    logic [DB:0]         den_reg, den_next;
    logic [NW-1:0]       num_reg, num_next;
    logic [NW-1:0]       dvs_reg, dvs_next;
    logic [PW-1:0]       quo_reg, quo_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    pens_pkg::note_t     out_data_reg, out_data_next;

    logic [DB-1:0]       n_clip;
    logic [PW-1:0]       diff_cand, diff_cur;
    logic                near_cand, near_cur;
    logic [DB:0]         fold_sum;
    logic [DB-1:0]       fold_dur;
    logic [DB-1:0]       den_sat;
    logic                out_free;
    logic [PW-1:0]       p_sel;
    logic [DB-1:0]       d_sel;
    logic [PW-1:0]       mul_a;
    logic [DB-1:0]       mul_b;
    logic [MW-1:0]       mul_y;
    logic [NW:0]         sub_y;
    logic                sub_ge;
    logic [XW-1:0]       px, ip_raw, frac, ip_rnd;
    logic                rnd_up;
    logic [pens_pkg::NOTE_W-1:0] note_num;
    logic                emit_step;

    if (DB >= FW) begin : g_dur_wide
        assign n_clip = DB'(evt.event_duration);
    end else begin : g_dur_narrow
        assign n_clip = (|evt.event_duration[FW-1:DB]) ? '1 : evt.event_duration[DB-1:0];
    end

    assign diff_cand = (e_reg > cand_pitch_reg) ? (e_reg - cand_pitch_reg)
                                                : (cand_pitch_reg - e_reg);
    assign diff_cur  = (e_reg > cur_pitch_reg) ? (e_reg - cur_pitch_reg)
                                               : (cur_pitch_reg - e_reg);
    assign near_cand = diff_cand < tol_reg;
    assign near_cur  = diff_cur < tol_reg;

    assign fold_sum = {1'b0, cur_dur_reg} + {1'b0, cand_dur_reg};
    assign fold_dur = fold_sum[DB] ? '1 : fold_sum[DB-1:0];
    assign den_sat  = den_reg[DB] ? '1 : den_reg[DB-1:0];

    assign out_free = !out_valid_reg || !note_stall;

    assign p_sel = tgt_cand_reg ? cand_pitch_reg : cur_pitch_reg;
    assign d_sel = tgt_cand_reg ? cand_dur_reg : cur_dur_reg;

    assign mul_a = (state_reg == MUL_E) ? e_reg : p_sel;
    assign mul_b = (state_reg == MUL_E) ? n_reg : d_sel;
    assign mul_y = MW'(mul_a) * MW'(mul_b);

    assign sub_y  = {1'b0, num_reg} - {1'b0, dvs_reg};
    assign sub_ge = !sub_y[NW];

    assign px     = XW'(cur_pitch_reg);
    assign ip_raw = px >> PITCH_FRAC_BITS;
    assign frac   = px & FRAC_MASK;
    assign rnd_up = (frac > FRAC_HALF) || ((frac == FRAC_HALF) && ip_raw[0]);
    assign ip_rnd = ip_raw + XW'(rnd_up);
    assign note_num = (ip_rnd > XW'(pens_pkg::NOTE_MAX)) ? pens_pkg::NOTE_MAX
                                                         : ip_rnd[pens_pkg::NOTE_W-1:0];

    always_comb
    begin
        logic          emit_req;
        logic [DB-1:0] emit_dur;
        logic [FW-1:0] emit_pause;
        logic [PW-1:0] new_p;

        state_next      = state_reg;
        tol_next        = tol_reg;
        maxd_next       = maxd_reg;
        active_next     = active_reg;
        cur_pitch_next  = cur_pitch_reg;
        cur_dur_next    = cur_dur_reg;
        cand_pitch_next = cand_pitch_reg;
        cand_dur_next   = cand_dur_reg;
        op_next         = op_reg;
        e_next          = e_reg;
        n_next          = n_reg;
        pause_next      = pause_reg;
        tgt_cand_next   = tgt_cand_reg;
        prod_next       = prod_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        dvs_next        = dvs_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        emit_req        = 1'b0;
        emit_dur        = cur_dur_reg;
        emit_pause      = '0;
        new_p           = den_reg == '0 ? p_sel : quo_reg;

        if (out_valid_reg && !note_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                pens_pkg::CFG_PITCH_TOL: tol_next  = cfg_data[PW-1:0];
                pens_pkg::CFG_MAX_CAND:  maxd_next = cfg_data[FW-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            IDLE:
            begin
                if (evt_valid)
                begin
                    op_next    = evt.op;
                    e_next     = evt.pitch;
                    n_next     = n_clip;
                    pause_next = evt.event_pause;
                    state_next = DECIDE;
                end
            end

            DECIDE:
            begin
                if (op_reg == pens_pkg::OP_FLUSH)
                begin
                    emit_req = CW'(fold_dur) > CW'(maxd_reg);
                    emit_dur = fold_dur;
                    if (!emit_req || out_free)
                    begin
                        cur_dur_next  = emit_req ? '0 : fold_dur;
                        cand_dur_next = '0;
                        active_next   = 1'b0;
                        state_next    = IDLE;
                    end
                end
                else if (pause_reg != '0)
                begin
                    emit_req   = 1'b1;
                    emit_dur   = fold_dur;
                    emit_pause = pause_reg;
                    if (out_free)
                    begin
                        cur_dur_next  = '0;
                        cand_dur_next = '0;
                        active_next   = 1'b0;
                        state_next    = IDLE;
                    end
                end
                else if (active_reg && near_cand)
                begin
                    tgt_cand_next = 1'b1;
                    state_next    = MUL_P;
                end
                else if (active_reg && near_cur)
                begin
                    cur_dur_next  = fold_dur;
                    cand_dur_next = '0;
                    active_next   = 1'b0;
                    tgt_cand_next = 1'b0;
                    state_next    = MUL_P;
                end
                else if (active_reg)
                begin
                    emit_req = 1'b1;
                    emit_dur = fold_dur;
                    if (out_free)
                    begin
                        cur_dur_next  = '0;
                        cand_dur_next = '0;
                        active_next   = 1'b0;
                        state_next    = IDLE;
                    end
                end
                else if (near_cur)
                begin
                    tgt_cand_next = 1'b0;
                    state_next    = MUL_P;
                end
                else
                begin
                    cand_pitch_next = e_reg;
                    cand_dur_next   = n_reg;
                    active_next     = 1'b1;
                    state_next      = IDLE;
                end
            end

            MUL_P:
            begin
                prod_next  = mul_y;
                den_next   = {1'b0, d_sel} + {1'b0, n_reg};
                state_next = MUL_E;
            end

            MUL_E:
            begin
                prod_next  = mul_y;
                num_next   = NW'(prod_reg) + NW'(den_reg >> 1);
                state_next = ACCUM;
            end

            ACCUM:
            begin
                num_next   = num_reg + NW'(prod_reg);
                dvs_next   = NW'(den_reg) << (PW - 1);
                quo_next   = '0;
                cnt_next   = '0;
                state_next = (den_reg == '0) ? FINISH : DIVIDE;
            end

            DIVIDE:
            begin
                if (sub_ge)
                begin
                    num_next = sub_y[NW-1:0];
                end
                quo_next = {quo_reg[PW-2:0], sub_ge};
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = FINISH;
                end
            end

            FINISH:
            begin
                if (tgt_cand_reg)
                begin
                    emit_req = CW'(den_sat) > CW'(maxd_reg);
                    emit_dur = cur_dur_reg;
                    if (!emit_req)
                    begin
                        cand_pitch_next = new_p;
                        cand_dur_next   = den_sat;
                        state_next      = IDLE;
                    end
                    else if (out_free)
                    begin
                        cand_pitch_next = new_p;
                        cur_pitch_next  = new_p;
                        cur_dur_next    = den_sat;
                        cand_dur_next   = '0;
                        active_next     = 1'b0;
                        state_next      = IDLE;
                    end
                end
                else
                begin
                    cur_pitch_next = new_p;
                    cur_dur_next   = den_sat;
                    state_next     = IDLE;
                end
            end

            default: state_next = IDLE;
        endcase

        if (emit_req && out_free)
        begin
            out_valid_next              = 1'b1;
            out_data_next.note_number   = note_num;
            out_data_next.mean_pitch    = cur_pitch_reg;
            out_data_next.note_duration = FW'(emit_dur);
            out_data_next.note_pause    = emit_pause;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            tol_reg        <= pens_pkg::TOL_RESET;
            maxd_reg       <= pens_pkg::MAXD_RESET;
            active_reg     <= 1'b0;
            cur_pitch_reg  <= '0;
            cur_dur_reg    <= '0;
            cand_pitch_reg <= '0;
            cand_dur_reg   <= '0;
            op_reg         <= 1'b0;
            e_reg          <= '0;
            n_reg          <= '0;
            pause_reg      <= '0;
            tgt_cand_reg   <= 1'b0;
            prod_reg       <= '0;
            den_reg        <= '0;
            num_reg        <= '0;
            dvs_reg        <= '0;
            quo_reg        <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            tol_reg        <= tol_next;
            maxd_reg       <= maxd_next;
            active_reg     <= active_next;
            cur_pitch_reg  <= cur_pitch_next;
            cur_dur_reg    <= cur_dur_next;
            cand_pitch_reg <= cand_pitch_next;
            cand_dur_reg   <= cand_dur_next;
            op_reg         <= op_next;
            e_reg          <= e_next;
            n_reg          <= n_next;
            pause_reg      <= pause_next;
            tgt_cand_reg   <= tgt_cand_next;
            prod_reg       <= prod_next;
            den_reg        <= den_next;
            num_reg        <= num_next;
            dvs_reg        <= dvs_next;
            quo_reg        <= quo_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    assign evt_stall  = (state_reg != IDLE);
    assign note_valid = out_valid_reg;
    assign note       = out_data_reg;
    assign emit_step  = (state_reg == DECIDE) || (state_reg == FINISH);

    `SEG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, evt_valid && !evt_stall, evt_stall)
    `SEG_ASSERT_IMPL(a_idle_cand_empty, clk, rst_n, !active_reg, cand_dur_reg == '0)
    `SEG_ASSERT_IMPL(a_note_from_emit, clk, rst_n, $rose(note_valid), $past(emit_step))

endmodule

FILE: test/pitch_event_note_segmenter_top_tb.sv
// Self-checking testbench for the pitch event note segmenter top level.
module pitch_event_note_segmenter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PITCH_W = pens_pkg::PITCH_W;
    localparam int FIELD_W = pens_pkg::FIELD_W;
    localparam int NOTE_W = pens_pkg::NOTE_W;
    localparam int FRAC_BITS = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic evt_valid = 1'b0;
    logic evt_stall;
    pens_pkg::evt_t evt = '0;
    logic note_valid;
    logic note_stall = 1'b0;
    pens_pkg::note_t note;
    logic cfg_we = 1'b0;
    logic cfg_index = pens_pkg::CFG_PITCH_TOL;
    logic [pens_pkg::CFG_W-1:0] cfg_data = '0;

    // Shadow copy of the segmenter state and its registers.
    logic [PITCH_W-1:0] tol_reg;
    logic [FIELD_W-1:0] maxd_reg;
    logic cand_on;
    logic [PITCH_W-1:0] cur_pitch;
    logic [FIELD_W-1:0] cur_dur;
    logic [PITCH_W-1:0] cand_pitch;
    logic [FIELD_W-1:0] cand_dur;

    pens_pkg::note_t expected_notes[$];

    int mismatch_cnt = 0;
    int event_cnt = 0;
    int flush_cnt = 0;
    int pause_cnt = 0;
    int note_cnt = 0;
    int settings_cnt = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_roll;
    logic stall_hold = 1'b0;

    pitch_event_note_segmenter_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt),
        .note_valid (note_valid),
        .note_stall (note_stall),
        .note       (note),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [FIELD_W-1:0] sat_sum(input logic [FIELD_W-1:0] a,
                                                   input logic [FIELD_W-1:0] b);
        logic [FIELD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FIELD_W] ? {FIELD_W{1'b1}} : s[FIELD_W-1:0];
    endfunction

    function automatic bit pitch_close(input logic [PITCH_W-1:0] a,
                                       input logic [PITCH_W-1:0] b);
        logic [PITCH_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d < tol_reg;
    endfunction

    function automatic pens_pkg::evt_t make_event(input logic op,
                                                  input logic [PITCH_W-1:0] pitch,
                                                  input logic [FIELD_W-1:0] dur,
                                                  input logic [FIELD_W-1:0] pause);
        pens_pkg::evt_t item;
        item.op = op;
        item.pitch = pitch;
        item.event_duration = dur;
        item.event_pause = pause;
        return item;
    endfunction

    task automatic blend_pitch(inout logic [PITCH_W-1:0] p, inout logic [FIELD_W-1:0] d,
                               input logic [PITCH_W-1:0] e, input logic [FIELD_W-1:0] n);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        den = 64'(d) + 64'(n);
        if (den != 0)
        begin
            num = 64'(p) * 64'(d) + 64'(e) * 64'(n) + den / 2;
            q = num / den;
            p = q[PITCH_W-1:0];
        end
        d = sat_sum(d, n);
    endtask

    task automatic fold_candidate();
        cur_dur = sat_sum(cur_dur, cand_dur);
        cand_dur = '0;
        cand_on = 1'b0;
    endtask

    task automatic close_note(input logic [FIELD_W-1:0] pause);
        pens_pkg::note_t nt;
        logic [7:0] ip;
        logic [FRAC_BITS-1:0] fr;
        ip = 8'(cur_pitch[PITCH_W-1:FRAC_BITS]);
        fr = cur_pitch[FRAC_BITS-1:0];
        if (fr > (1 << (FRAC_BITS - 1)) || (fr == (1 << (FRAC_BITS - 1)) && ip[0]))
            ip = ip + 8'd1;
        if (ip > {1'b0, pens_pkg::NOTE_MAX})
            ip = {1'b0, pens_pkg::NOTE_MAX};
        nt.note_number = ip[NOTE_W-1:0];
        nt.mean_pitch = cur_pitch;
        nt.note_duration = cur_dur;
        nt.note_pause = pause;
        expected_notes.push_back(nt);
        cur_dur = '0;
    endtask

    task automatic segment_event(input pens_pkg::evt_t item);
        logic [PITCH_W-1:0] e;
        logic [FIELD_W-1:0] n;
        e = item.pitch;
        n = item.event_duration;
        if (item.op == pens_pkg::OP_FLUSH)
        begin
            fold_candidate();
            if (cur_dur > maxd_reg)
                close_note('0);
        end
        else if (item.event_pause != '0)
        begin
            fold_candidate();
            close_note(item.event_pause);
        end
        else if (cand_on)
        begin
            if (pitch_close(e, cand_pitch))
            begin
                blend_pitch(cand_pitch, cand_dur, e, n);
                if (cand_dur > maxd_reg)
                begin
                    close_note('0);
                    cur_pitch = cand_pitch;
                    cur_dur = cand_dur;
                    cand_dur = '0;
                    cand_on = 1'b0;
                end
            end
            else if (pitch_close(e, cur_pitch))
            begin
                fold_candidate();
                blend_pitch(cur_pitch, cur_dur, e, n);
            end
            else
            begin
                fold_candidate();
                close_note('0);
            end
        end
        else if (pitch_close(e, cur_pitch))
            blend_pitch(cur_pitch, cur_dur, e, n);
        else
        begin
            cand_pitch = e;
            cand_dur = n;
            cand_on = 1'b1;
        end
    endtask

    task automatic send_event(input pens_pkg::evt_t item);
        int gap;
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end
            else if (r < 45)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt <= item;
        evt_valid <= 1'b1;
        do
            @(posedge clk);
        while (evt_stall);
        segment_event(item);
        event_cnt++;
        if (item.op == pens_pkg::OP_FLUSH)
            flush_cnt++;
        else if (item.event_pause != '0)
            pause_cnt++;
    endtask

    task automatic wait_idle();
        evt_valid <= 1'b0;
        while (expected_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(input logic [PITCH_W-1:0] tol, input logic [FIELD_W-1:0] maxd);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= pens_pkg::CFG_PITCH_TOL;
        cfg_data <= pens_pkg::CFG_W'(tol);
        @(posedge clk);
        tol_reg = tol;
        cfg_index <= pens_pkg::CFG_MAX_CAND;
        cfg_data <= maxd;
        @(posedge clk);
        maxd_reg = maxd;
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_cnt++;
    endtask

    // Mostly runs of nearby pitches with random lengths, broken by pitch jumps,
    // pauses and flushes, with a share of fully random transactions.
    task automatic run_stream(input int count);
        logic [PITCH_W-1:0] base;
        logic [63:0] raw;
        logic [FIELD_W-1:0] dur;
        pens_pkg::evt_t item;
        int r;
        int span;
        int v;
        base = PITCH_W'($urandom);
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r >= 10 && r < 20)
                base = PITCH_W'($urandom);
            span = (int'(tol_reg) - 1) / 2;
            v = int'(base) - span + int'($urandom_range(0, 2 * span));
            if (v < 0)
                v = 0;
            if (v > 32767)
                v = 32767;
            case ($urandom_range(0, 9))
                0: dur = '0;
                1, 2, 3, 4, 5: dur = FIELD_W'($urandom_range(1, 20));
                6, 7: dur = FIELD_W'($urandom_range(21, 300));
                8: dur = FIELD_W'($urandom);
                default: dur = {FIELD_W{1'b1}};
            endcase
            item = make_event(pens_pkg::OP_EVENT, PITCH_W'(v), dur, '0);
            if (r < 10)
            begin
                raw = {$urandom, $urandom};
                item = raw[$bits(pens_pkg::evt_t)-1:0];
            end
            else if (r >= 20 && r < 28)
            begin
                if ($urandom_range(0, 9) < 8)
                    item.event_pause = FIELD_W'($urandom_range(1, 500));
                else if ($urandom_range(0, 1) == 0)
                    item.event_pause = FIELD_W'($urandom_range(1, 65535));
                else
                    item.event_pause = {FIELD_W{1'b1}};
            end
            else if (r >= 28 && r < 31)
            begin
                raw = {$urandom, $urandom};
                item = raw[$bits(pens_pkg::evt_t)-1:0];
                item.op = pens_pkg::OP_FLUSH;
            end
            else if (r >= 31 && r < 35)
                item.pitch = ($urandom_range(0, 1) == 0) ? '0 : {PITCH_W{1'b1}};
            send_event(item);
        end
        send_event(make_event(pens_pkg::OP_FLUSH, '0, '0, '0));
    endtask

    task automatic test_merge_and_close();
        send_event(make_event(pens_pkg::OP_EVENT, 15'h0000, 16'd0, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'd100, 16'd10, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h7FFF, 16'd20, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h7FFF - 15'd127, 16'd20, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'd150, 16'd5, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h4000, 16'd8, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h2000, 16'd9, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h2000, 16'd0, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h2000, 16'hFFFF, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h2010, 16'hFFFF, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h1234, 16'd77, 16'hFFFF));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h1200, 16'd3, 16'd0));
        send_event(make_event(pens_pkg::OP_FLUSH, 15'h7FFF, 16'hFFFF, 16'hFFFF));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h2005, 16'd60, 16'd0));
        send_event(make_event(pens_pkg::OP_FLUSH, 15'h0000, 16'd0, 16'd0));
        send_event(make_event(pens_pkg::OP_EVENT, 15'h0000, 16'd1, 16'd1));
    endtask

    task automatic test_note_rounding();
        logic [PITCH_W-1:0] ties[5];
        ties = '{15'h0080, 15'h0180, 15'h7E80, 15'h7F80, 15'h7FFF};
        set_registers({PITCH_W{1'b1}}, '0);
        foreach (ties[i])
        begin
            send_event(make_event(pens_pkg::OP_EVENT, ties[i], 16'd1, 16'd0));
            send_event(make_event(pens_pkg::OP_EVENT, 15'h5555, 16'h5555, 16'd1));
        end
    endtask

    task automatic test_default_stream();
        set_registers(pens_pkg::TOL_RESET, pens_pkg::MAXD_RESET);
        run_stream(250);
    endtask

    task automatic test_extreme_settings();
        set_registers(15'd1, 16'd0);
        run_stream(150);
        set_registers({PITCH_W{1'b1}}, {FIELD_W{1'b1}});
        run_stream(150);
        set_registers({PITCH_W{1'b1}}, 16'd0);
        run_stream(100);
        set_registers(15'd1, {FIELD_W{1'b1}});
        run_stream(100);
    endtask

    task automatic test_random_settings();
        for (int i = 0; i < 4; i++)
        begin
            if (i == 3)
                set_registers(PITCH_W'($urandom_range(1, 32767)), FIELD_W'($urandom));
            else
                set_registers(PITCH_W'($urandom_range(1, 1024)),
                              FIELD_W'($urandom_range(0, 400)));
            run_stream(220);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            stall_hold = (stall_roll >= 55);
            if (stall_roll < 40)
                stall_left = $urandom_range(1, 8);
            else if (stall_roll < 55)
                stall_left = $urandom_range(20, 100);
            else if (stall_roll < 90)
                stall_left = $urandom_range(0, 2);
            else
                stall_left = $urandom_range(10, 40);
        end
        note_stall <= stall_hold;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (note_valid && !note_stall)
            begin
                note_cnt++;
                if (expected_notes.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("Unexpected note: number %0d pitch %h duration %0d pause %0d",
                                 note.note_number, note.mean_pitch, note.note_duration,
                                 note.note_pause);
                end
                else if (note != expected_notes[0])
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"Note mismatch: expected %0d/%h/%0d/%0d ",
                                  "actual %0d/%h/%0d/%0d (number/pitch/duration/pause)"},
                                 expected_notes[0].note_number, expected_notes[0].mean_pitch,
                                 expected_notes[0].note_duration, expected_notes[0].note_pause,
                                 note.note_number, note.mean_pitch, note.note_duration,
                                 note.note_pause);
                    void'(expected_notes.pop_front());
                end
                else
                    void'(expected_notes.pop_front());
            end
            if ((evt_valid && !evt_stall) || (note_valid && !note_stall) || cfg_we)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Timeout after %0d cycles without a transaction", quiet_cycles);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        tol_reg = pens_pkg::TOL_RESET;
        maxd_reg = pens_pkg::MAXD_RESET;
        cand_on = 1'b0;
        cur_pitch = '0;
        cur_dur = '0;
        cand_pitch = '0;
        cand_dur = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_merge_and_close();
        test_note_rounding();
        test_default_stream();
        test_extreme_settings();
        test_random_settings();

        wait_idle();
        $display("Sent %0d transactions (%0d flushes, %0d pauses) and checked %0d notes",
                 event_cnt, flush_cnt, pause_cnt, note_cnt);
        $display("across %0d register settings, including the extreme tolerances and limits.",
                 settings_cnt);
        if (mismatch_cnt == 0 && expected_notes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches, %0d notes missing", mismatch_cnt, expected_notes.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
